// ===== hw/rtl/sorted_key_table_lower_bound_defines.svh =====
// Assertion macros used by the checker file of the sorted key table.
`ifndef SORTED_KEY_TABLE_LOWER_BOUND_DEFINES_SVH
`define SORTED_KEY_TABLE_LOWER_BOUND_DEFINES_SVH

// Implication that must hold in the cycle after the antecedent.
`define SKTLB_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Implication that must hold in the same cycle as the antecedent.
`define SKTLB_ASSERT_SAME(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/sktlb_pkg.sv =====
// Shared types, codes and constants of the sorted key table.
package sktlb_pkg;

   localparam int TABLE_DEPTH_DEFAULT  = 256;
   localparam int KEY_WIDTH_DEFAULT    = 32;
   localparam int HANDLE_WIDTH_DEFAULT = 32;

   localparam int CAPACITY_LIMIT = 254;
   localparam int CAP_WIDTH      = 8;
   localparam int COUNT_WIDTH    = 8;
   localparam int ROW_WIDTH      = 9;

   localparam logic [CAP_WIDTH-1:0] CAPACITY_RESET = CAP_WIDTH'(CAPACITY_LIMIT);

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef enum logic [1:0] {
      CMD_APPEND      = 2'd0,
      CMD_SORT        = 2'd1,
      CMD_LOWER_BOUND = 2'd2,
      CMD_EXACT       = 2'd3
   } command_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_APPEND,
      ST_SEARCH,
      ST_FETCH,
      ST_SORT_LOAD,
      ST_SORT_HOLD,
      ST_SORT_SCAN,
      ST_SORT_PLACE,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [ROW_WIDTH-1:0] row_index;
      logic                 hit;
      logic [ROW_WIDTH-1:0] live_count;
      logic                 status;
   } result_type;

   typedef struct packed {
      logic start;
      logic out_free;
   } ctrl_cmd_type;

   typedef struct packed {
      logic idle;
      logic done;
   } ctrl_status_type;

endpackage

// ===== hw/rtl/sktlb_req_if.sv =====
// Request channel interface: command, key and handle with valid and ready.
interface sktlb_req_if #(
   parameter int KEY_WIDTH    = sktlb_pkg::KEY_WIDTH_DEFAULT,
   parameter int HANDLE_WIDTH = sktlb_pkg::HANDLE_WIDTH_DEFAULT
);
   logic                     valid;
   logic                     ready;
   sktlb_pkg::command_type   command;
   logic [KEY_WIDTH-1:0]     key;
   logic [HANDLE_WIDTH-1:0]  handle;

   modport source (output valid, output command, output key, output handle, input ready);
   modport sink   (input valid, input command, input key, input handle, output ready);
endinterface

// ===== hw/rtl/sktlb_rsp_if.sv =====
// Response channel interface: lookup and append results with valid and ready.
interface sktlb_rsp_if #(
   parameter int HANDLE_WIDTH = sktlb_pkg::HANDLE_WIDTH_DEFAULT
);
   logic                                valid;
   logic                                ready;
   logic [sktlb_pkg::ROW_WIDTH-1:0]     row_index;
   logic [HANDLE_WIDTH-1:0]             row_handle;
   logic                                hit;
   logic [sktlb_pkg::ROW_WIDTH-1:0]     live_count;
   logic                                status;

   modport source (output valid, output row_index, output row_handle, output hit,
                   output live_count, output status, input ready);
   modport sink   (input valid, input row_index, input row_handle, input hit,
                   input live_count, input status, output ready);
endinterface

// ===== hw/rtl/sktlb_row_mem.sv =====
// Row memory holding key and handle pairs, one write and one registered read port.
module sktlb_row_mem #(
   parameter int  DEPTH      = sktlb_pkg::TABLE_DEPTH_DEFAULT,
   parameter int  WIDTH      = sktlb_pkg::KEY_WIDTH_DEFAULT + sktlb_pkg::HANDLE_WIDTH_DEFAULT,
   localparam int ADDR_WIDTH = $clog2(DEPTH)
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_WIDTH-1:0] wr_addr,
   input  logic [WIDTH-1:0]      wr_data,
   input  logic                  rd_en,
   input  logic [ADDR_WIDTH-1:0] rd_addr,
   output logic [WIDTH-1:0]      rd_data
);

   logic [WIDTH-1:0] store_mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/sktlb_ctrl.sv =====
// Command sequencer: append, insertion sort and binary search over the row memory.
module sktlb_ctrl #(
   parameter int  TABLE_DEPTH  = sktlb_pkg::TABLE_DEPTH_DEFAULT,
   parameter int  KEY_WIDTH    = sktlb_pkg::KEY_WIDTH_DEFAULT,
   parameter int  HANDLE_WIDTH = sktlb_pkg::HANDLE_WIDTH_DEFAULT,
   localparam int ADDR_WIDTH   = $clog2(TABLE_DEPTH),
   localparam int ROW_BITS     = KEY_WIDTH + HANDLE_WIDTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  sktlb_pkg::ctrl_cmd_type             cmd,
   output sktlb_pkg::ctrl_status_type          status,
   input  sktlb_pkg::command_type              req_command,
   input  logic [KEY_WIDTH-1:0]                req_key,
   input  logic [HANDLE_WIDTH-1:0]             req_handle,
   input  logic                                csr_wr_en,
   input  logic [sktlb_pkg::CAP_WIDTH-1:0]     csr_wr_data,
   output sktlb_pkg::result_type               result,
   output logic [HANDLE_WIDTH-1:0]             result_handle,
   output logic                                mem_wr_en,
   output logic [ADDR_WIDTH-1:0]               mem_wr_addr,
   output logic [ROW_BITS-1:0]                 mem_wr_data,
   output logic                                mem_rd_en,
   output logic [ADDR_WIDTH-1:0]               mem_rd_addr,
   input  logic [ROW_BITS-1:0]                 mem_rd_data
);

   localparam int CW = sktlb_pkg::COUNT_WIDTH;
   localparam int RW = sktlb_pkg::ROW_WIDTH;
   localparam int CAP_LIMIT = (sktlb_pkg::CAPACITY_LIMIT < TABLE_DEPTH) ?
                              sktlb_pkg::CAPACITY_LIMIT : TABLE_DEPTH;
   localparam logic [sktlb_pkg::CAP_WIDTH-1:0] CAP_MAX = sktlb_pkg::CAP_WIDTH'(CAP_LIMIT);

   sktlb_pkg::state_type    state_ff, state_in;
   sktlb_pkg::command_type  cmd_ff, cmd_in;
   logic [KEY_WIDTH-1:0]    key_ff, key_in;
   logic [HANDLE_WIDTH-1:0] handle_ff, handle_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [sktlb_pkg::CAP_WIDTH-1:0] cap_ff;
   logic [CW-1:0]           low_ff, low_in;
   logic [CW-1:0]           span_ff, span_in;
   logic                    pend_ff, pend_in;
   logic [CW-1:0]           sweep_ff, sweep_in;
   logic [CW-1:0]           slot_ff, slot_in;
   sktlb_pkg::result_type   res_ff, res_in;
   logic [HANDLE_WIDTH-1:0] res_handle_ff, res_handle_in;

   logic [KEY_WIDTH-1:0]    rd_key;
   logic [HANDLE_WIDTH-1:0] rd_handle;
   logic [CW-1:0]           half;
   logic [CW-1:0]           probe;
   logic [CW-1:0]           low_n;
   logic [CW-1:0]           span_n;
   logic [CW-1:0]           next_probe;
   logic [sktlb_pkg::CAP_WIDTH-1:0] eff_cap;
   logic                    room;
   logic                    scan_less;
   logic [CW-1:0]           slot_dec;
   logic                    in_table;
   logic                    lookup_hit;

   assign rd_key    = mem_rd_data[ROW_BITS-1 -: KEY_WIDTH];
   assign rd_handle = mem_rd_data[HANDLE_WIDTH-1:0];

   // One binary-search step: the probe issued last cycle is compared against
   // the registered read data and the window shrinks accordingly.
   always_comb begin
      half  = span_ff >> 1;
      probe = low_ff + half;
      if (pend_ff && (rd_key < key_ff)) begin
         low_n  = probe + CW'(1);
         span_n = span_ff - half - CW'(1);
      end else if (pend_ff) begin
         low_n  = low_ff;
         span_n = half;
      end else begin
         low_n  = low_ff;
         span_n = span_ff;
      end
      next_probe = low_n + (span_n >> 1);
   end

   assign eff_cap    = (cap_ff > CAP_MAX) ? CAP_MAX : cap_ff;
   assign room       = count_ff < CW'(eff_cap);
   assign scan_less  = key_ff < rd_key;
   assign slot_dec   = slot_ff - CW'(1);
   assign in_table   = low_ff < count_ff;
   assign lookup_hit = in_table &&
                       ((cmd_ff == sktlb_pkg::CMD_LOWER_BOUND) || (rd_key == key_ff));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sktlb_pkg::ST_IDLE: begin
            if (cmd.start) begin
               unique case (req_command)
                  sktlb_pkg::CMD_APPEND:      state_in = sktlb_pkg::ST_APPEND;
                  sktlb_pkg::CMD_SORT:        state_in = sktlb_pkg::ST_SORT_LOAD;
                  sktlb_pkg::CMD_LOWER_BOUND: state_in = sktlb_pkg::ST_SEARCH;
                  sktlb_pkg::CMD_EXACT:       state_in = sktlb_pkg::ST_SEARCH;
                  default:                    state_in = sktlb_pkg::ST_SEARCH;
               endcase
            end
         end
         sktlb_pkg::ST_APPEND: state_in = sktlb_pkg::ST_RESP;
         sktlb_pkg::ST_SEARCH: begin
            if (span_n == '0) begin
               state_in = sktlb_pkg::ST_FETCH;
            end
         end
         sktlb_pkg::ST_FETCH: state_in = sktlb_pkg::ST_RESP;
         sktlb_pkg::ST_SORT_LOAD: begin
            if (sweep_ff >= count_ff) begin
               state_in = sktlb_pkg::ST_RESP;
            end else begin
               state_in = sktlb_pkg::ST_SORT_HOLD;
            end
         end
         sktlb_pkg::ST_SORT_HOLD: state_in = sktlb_pkg::ST_SORT_SCAN;
         sktlb_pkg::ST_SORT_SCAN: begin
            if (scan_less && (slot_dec == '0)) begin
               state_in = sktlb_pkg::ST_SORT_PLACE;
            end else if (!scan_less) begin
               state_in = sktlb_pkg::ST_SORT_LOAD;
            end
         end
         sktlb_pkg::ST_SORT_PLACE: state_in = sktlb_pkg::ST_SORT_LOAD;
         sktlb_pkg::ST_RESP: begin
            if (cmd.out_free) begin
               state_in = sktlb_pkg::ST_IDLE;
            end
         end
         default: state_in = sktlb_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      handle_in     = handle_ff;
      count_in      = count_ff;
      low_in        = low_ff;
      span_in       = span_ff;
      pend_in       = pend_ff;
      sweep_in      = sweep_ff;
      slot_in       = slot_ff;
      res_in        = res_ff;
      res_handle_in = res_handle_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = '0;
      mem_wr_data   = '0;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = '0;
      status.idle   = 1'b0;
      status.done   = 1'b0;
      unique case (state_ff)
         sktlb_pkg::ST_IDLE: begin
            status.idle = 1'b1;
            if (cmd.start) begin
               cmd_in    = req_command;
               key_in    = req_key;
               handle_in = req_handle;
               low_in    = '0;
               span_in   = count_ff;
               pend_in   = 1'b0;
               sweep_in  = CW'(1);
            end
         end
         sktlb_pkg::ST_APPEND: begin
            res_in.row_index = RW'(count_ff);
            res_in.hit       = 1'b0;
            res_handle_in    = '0;
            if (room) begin
               mem_wr_en         = 1'b1;
               mem_wr_addr       = ADDR_WIDTH'(count_ff);
               mem_wr_data       = {key_ff, handle_ff};
               count_in          = count_ff + CW'(1);
               res_in.live_count = RW'(count_ff + CW'(1));
               res_in.status     = sktlb_pkg::STATUS_OK;
            end else begin
               res_in.live_count = RW'(count_ff);
               res_in.status     = sktlb_pkg::STATUS_FULL;
            end
         end
         sktlb_pkg::ST_SEARCH: begin
            low_in    = low_n;
            span_in   = span_n;
            pend_in   = 1'b1;
            mem_rd_en = 1'b1;
            // When the window closes, the last read fetches the bound row itself.
            mem_rd_addr = (span_n != '0) ? ADDR_WIDTH'(next_probe) : ADDR_WIDTH'(low_n);
         end
         sktlb_pkg::ST_FETCH: begin
            res_in.row_index  = RW'(low_ff);
            res_in.hit        = lookup_hit;
            res_in.live_count = RW'(count_ff);
            res_in.status     = sktlb_pkg::STATUS_OK;
            res_handle_in     = lookup_hit ? rd_handle : '0;
         end
         sktlb_pkg::ST_SORT_LOAD: begin
            if (sweep_ff >= count_ff) begin
               res_in.row_index  = '0;
               res_in.hit        = 1'b0;
               res_in.live_count = RW'(count_ff);
               res_in.status     = sktlb_pkg::STATUS_OK;
               res_handle_in     = '0;
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = ADDR_WIDTH'(sweep_ff);
            end
         end
         sktlb_pkg::ST_SORT_HOLD: begin
            key_in      = rd_key;
            handle_in   = rd_handle;
            slot_in     = sweep_ff;
            mem_rd_en   = 1'b1;
            mem_rd_addr = ADDR_WIDTH'(sweep_ff - CW'(1));
         end
         sktlb_pkg::ST_SORT_SCAN: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = ADDR_WIDTH'(slot_ff);
            if (scan_less) begin
               // Shift the larger row up one slot and look one row further down.
               mem_wr_data = mem_rd_data;
               slot_in     = slot_dec;
               if (slot_dec != '0) begin
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = ADDR_WIDTH'(slot_dec - CW'(1));
               end
            end else begin
               mem_wr_data = {key_ff, handle_ff};
               sweep_in    = sweep_ff + CW'(1);
            end
         end
         sktlb_pkg::ST_SORT_PLACE: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = ADDR_WIDTH'(slot_ff);
            mem_wr_data = {key_ff, handle_ff};
            sweep_in    = sweep_ff + CW'(1);
         end
         sktlb_pkg::ST_RESP: begin
            status.done = cmd.out_free;
         end
         default: begin
            status.idle = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sktlb_pkg::ST_IDLE;
         count_ff <= '0;
         cap_ff   <= sktlb_pkg::CAPACITY_RESET;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      handle_ff     <= handle_in;
      low_ff        <= low_in;
      span_ff       <= span_in;
      sweep_ff      <= sweep_in;
      slot_ff       <= slot_in;
      res_ff        <= res_in;
      res_handle_ff <= res_handle_in;
   end

   assign result        = res_ff;
   assign result_handle = res_handle_ff;

endmodule

// ===== hw/rtl/sorted_key_table_lower_bound.sv =====
// Top level of the sorted key table: sequencer, row memory and response register.
//
//   Channel  Direction  Handshake          Carries
//   req_ch   in         valid / ready      command, key, handle
//   rsp_ch   out        valid / ready      row_index, row_handle, hit, live_count, status
//   csr_*    in         csr_wr_en strobe   table_capacity (8 bits)
//
// One transaction at a time; req_ch.ready is high only while the sequencer is idle.
// A lookup makes one memory probe per cycle on the single read port.
// Sort takes each row after the first through load, hold and scan, shifting every
// larger row up one slot before the row is written into the freed slot.
// Synchronous reset clears the live count and sets the capacity to 254; rows are not cleared.
// A waiting response sits in the output register; the next command still runs, then
// waits to hand over its response, and no request is taken in the meantime.
module sorted_key_table_lower_bound #(
   parameter int TABLE_DEPTH  = sktlb_pkg::TABLE_DEPTH_DEFAULT,
   parameter int KEY_WIDTH    = sktlb_pkg::KEY_WIDTH_DEFAULT,
   parameter int HANDLE_WIDTH = sktlb_pkg::HANDLE_WIDTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   sktlb_req_if.sink                        req_ch,
   sktlb_rsp_if.source                      rsp_ch,
   input  logic                             csr_wr_en,
   input  logic [sktlb_pkg::CAP_WIDTH-1:0]  csr_wr_data
);

   localparam int ADDR_WIDTH = $clog2(TABLE_DEPTH);
   localparam int ROW_BITS   = KEY_WIDTH + HANDLE_WIDTH;

   sktlb_pkg::ctrl_cmd_type    ctrl_cmd;
   sktlb_pkg::ctrl_status_type ctrl_status;
   sktlb_pkg::result_type      result;
   logic [HANDLE_WIDTH-1:0]    result_handle;

   logic                       mem_wr_en;
   logic [ADDR_WIDTH-1:0]      mem_wr_addr;
   logic [ROW_BITS-1:0]        mem_wr_data;
   logic                       mem_rd_en;
   logic [ADDR_WIDTH-1:0]      mem_rd_addr;
   logic [ROW_BITS-1:0]        mem_rd_data;

   logic                       rsp_valid_ff, rsp_valid_in;
   sktlb_pkg::result_type      rsp_result_ff;
   logic [HANDLE_WIDTH-1:0]    rsp_handle_ff;

   assign ctrl_cmd.start    = req_ch.valid && req_ch.ready;
   assign ctrl_cmd.out_free = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready      = ctrl_status.idle;

   sktlb_ctrl #(
      .TABLE_DEPTH  (TABLE_DEPTH),
      .KEY_WIDTH    (KEY_WIDTH),
      .HANDLE_WIDTH (HANDLE_WIDTH)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .cmd           (ctrl_cmd),
      .status        (ctrl_status),
      .req_command   (req_ch.command),
      .req_key       (req_ch.key),
      .req_handle    (req_ch.handle),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .result        (result),
      .result_handle (result_handle),
      .mem_wr_en     (mem_wr_en),
      .mem_wr_addr   (mem_wr_addr),
      .mem_wr_data   (mem_wr_data),
      .mem_rd_en     (mem_rd_en),
      .mem_rd_addr   (mem_rd_addr),
      .mem_rd_data   (mem_rd_data)
   );

   sktlb_row_mem #(
      .DEPTH (TABLE_DEPTH),
      .WIDTH (ROW_BITS)
   ) u_row_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   always_comb begin
      if (ctrl_status.done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl_status.done) begin
         rsp_result_ff <= result;
         rsp_handle_ff <= result_handle;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.row_index  = rsp_result_ff.row_index;
   assign rsp_ch.row_handle = rsp_handle_ff;
   assign rsp_ch.hit        = rsp_result_ff.hit;
   assign rsp_ch.live_count = rsp_result_ff.live_count;
   assign rsp_ch.status     = rsp_result_ff.status;

endmodule

// ===== hw/rtl/sktlb_checker.sv =====
// Port-level assertions for the sorted key table, bound to the top level.
`include "sorted_key_table_lower_bound_defines.svh"

module sktlb_checker #(
   parameter int HANDLE_WIDTH = sktlb_pkg::HANDLE_WIDTH_DEFAULT
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [sktlb_pkg::ROW_WIDTH-1:0] rsp_row_index,
   input logic [HANDLE_WIDTH-1:0]         rsp_row_handle,
   input logic                            rsp_hit,
   input logic [sktlb_pkg::ROW_WIDTH-1:0] rsp_live_count,
   input logic                            rsp_status
);

   localparam int PAYLOAD_BITS = 2 * sktlb_pkg::ROW_WIDTH + HANDLE_WIDTH + 2;

   logic                    rsp_stall;
   logic                    req_take;
   logic                    rsp_refused;
   logic                    refused_ok;
   logic [PAYLOAD_BITS-1:0] rsp_bits;

   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign req_take    = req_valid && req_ready;
   assign rsp_refused = rsp_valid && (rsp_status == sktlb_pkg::STATUS_FULL);
   assign rsp_bits    = {rsp_row_index, rsp_row_handle, rsp_hit, rsp_live_count, rsp_status};
   assign refused_ok  = !rsp_hit && (rsp_row_handle == '0) &&
                        (rsp_row_index == rsp_live_count) &&
                        (rsp_live_count <= sktlb_pkg::ROW_WIDTH'(sktlb_pkg::CAPACITY_LIMIT));

   `SKTLB_ASSERT_NEXT(a_valid_hold, clock, reset, rsp_stall, rsp_valid, "rsp valid dropped")

   `SKTLB_ASSERT_NEXT(a_payload_hold, clock, reset, rsp_stall, $stable(rsp_bits), "rsp changed")

   // The table works on one transaction at a time.
   `SKTLB_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_take, !req_ready, "second request taken")

   // A refused append reports the live count as its row and carries no handle.
   `SKTLB_ASSERT_SAME(a_refused_append, clock, reset, rsp_refused, refused_ok, "bad refusal")

endmodule

bind sorted_key_table_lower_bound sktlb_checker #(
   .HANDLE_WIDTH (HANDLE_WIDTH)
) u_sktlb_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_row_index  (rsp_ch.row_index),
   .rsp_row_handle (rsp_ch.row_handle),
   .rsp_hit        (rsp_ch.hit),
   .rsp_live_count (rsp_ch.live_count),
   .rsp_status     (rsp_ch.status)
);
